/* rtl/epi_pkg.sv */
// Shared types, constants and state encoding for the envelope point interpolation core.
`default_nettype none
package epi_pkg;

  localparam int EPI_MAX_POINTS = 32;

  localparam int TICK_W   = 16;
  localparam int VAL_W    = 8;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = 5;
  localparam int NCNT_W   = 6;
  localparam int RIN_W    = 8;
  localparam int ROUT_W   = 15;
  localparam int ENV_W    = 15;

  // Shared divider: quotient bits, divisor bits, dividend bits
  localparam int DIV_Q_W  = 24;
  localparam int DIV_D_W  = 16;
  localparam int DIV_N_W  = DIV_Q_W + DIV_D_W;
  localparam int DIV_C_W  = $clog2(DIV_Q_W);

  localparam int ENV_ONE  = 1 << FRAC_W;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_RANGE_IN   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  point_index;
    logic [TICK_W-1:0] point_tick;
    logic [VAL_W-1:0]  point_value;
    logic [TICK_W-1:0] position;
    logic [ROUT_W-1:0] range_out;
  } in_item_t;

  typedef struct packed {
    logic [ENV_W-1:0] envelope_value;
    logic             was_query;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [VAL_W-1:0]  value;
  } point_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_Y2_GO,
    ST_Y2_WAIT,
    ST_Y1_GO,
    ST_Y1_WAIT,
    ST_MUL,
    ST_DI_GO,
    ST_DI_WAIT,
    ST_SCALE,
    ST_ROUND
  } epi_state_t;

endpackage
`default_nettype wire

/* rtl/epi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module epi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* rtl/epi_div.sv */
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none
module epi_div
  import epi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_Q_W-1:0] sh_r, sh_nxt;
  logic [DIV_D_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_C_W-1:0] cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;

  logic [DIV_D_W:0] trial;
  logic [DIV_D_W:0] diff;
  logic             ge;

  // Caller guarantees the dividend's top part is below the divisor
  assign trial = {rem_r, sh_r[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = req.dividend[DIV_N_W-1:DIV_Q_W];
      sh_nxt  = req.dividend[DIV_Q_W-1:0];
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      sh_nxt  = {sh_r[DIV_Q_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_C_W'(DIV_Q_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = sh_r;

endmodule
`default_nettype wire

/* rtl/epi_ctrl.sv */
// Sequencer and datapath: point scan, divider scheduling, interpolation and output scaling.
`default_nettype none
module epi_ctrl
  import epi_pkg::*;
#(
  parameter int MAX_POINTS = EPI_MAX_POINTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire in_item_t                      in_data,
  output logic                               out_strobe,
  output out_item_t                          out_data,
  input  wire logic [NCNT_W-1:0]             node_count,
  input  wire logic [RIN_W-1:0]              range_in,
  output logic                               ram_we,
  output logic      [$clog2(MAX_POINTS)-1:0] ram_waddr,
  output point_t                             ram_wdata,
  output logic      [$clog2(MAX_POINTS)-1:0] ram_raddr,
  input  wire point_t                        ram_rdata,
  output div_req_t                           div_req,
  input  wire div_rsp_t                      div_rsp
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = ($clog2(MAX_POINTS + 1) > NCNT_W) ? $clog2(MAX_POINTS + 1) : NCNT_W;

  epi_state_t state_r, state_nxt;

  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]       last_r, last_nxt;
  logic [TICK_W-1:0]   pos_r, pos_nxt;
  logic [ROUT_W-1:0]   rout_r, rout_nxt;
  logic [RIN_W-1:0]    rin_r, rin_nxt;
  logic [TICK_W-1:0]   prev_tick_r, prev_tick_nxt;
  logic [VAL_W-1:0]    prev_val_r, prev_val_nxt;
  logic [TICK_W-1:0]   x1_r, x1_nxt;
  logic [TICK_W-1:0]   x2_r, x2_nxt;
  logic [VAL_W-1:0]    v1_r, v1_nxt;
  logic [VAL_W-1:0]    v2_r, v2_nxt;
  logic                pt0_r, pt0_nxt;
  logic [DIV_Q_W-1:0]  y1_r, y1_nxt;
  logic [DIV_Q_W-1:0]  y2_r, y2_nxt;
  logic [DIV_Q_W-1:0]  val_r, val_nxt;
  logic                neg_r, neg_nxt;
  logic [DIV_N_W-1:0]  prod_r, prod_nxt;
  logic [DIV_D_W-1:0]  den_r, den_nxt;
  logic [31:0]         sc_r, sc_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [CW-1:0]       nc_ext;
  logic [CW-1:0]       n_eff;
  logic                accept;
  logic                idx_ok;
  logic                interp;
  logic [DIV_Q_W-1:0]  mag;
  logic [TICK_W-1:0]   dpos;
  logic [DIV_N_W-1:0]  mul_w;
  logic [FRAC_W:0]     clamp_v;
  logic [32:0]         rnd_sum;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Clamp the point count to [1, MAX_POINTS]
  assign nc_ext = CW'(node_count);
  always_comb begin
    if (nc_ext == '0) begin
      n_eff = CW'(1);
    end else if (nc_ext > CW'(MAX_POINTS)) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = nc_ext;
    end
  end

  assign idx_ok    = int'(in_data.point_index) < MAX_POINTS;
  assign ram_we    = accept && (in_data.action == ACT_WRITE) && idx_ok;
  assign ram_waddr = AW'(in_data.point_index);
  assign ram_wdata = '{tick: in_data.point_tick, value: in_data.point_value};
  assign ram_raddr = rd_idx_r;

  assign interp  = (x2_r > x1_r) && (pos_r > x1_r);
  assign mag     = neg_r ? (y1_r - y2_r) : (y2_r - y1_r);
  assign dpos    = pos_r - x1_r;
  assign mul_w   = mag * dpos;
  assign clamp_v = (val_r > DIV_Q_W'(ENV_ONE)) ? (FRAC_W + 1)'(ENV_ONE) : val_r[FRAC_W:0];
  assign rnd_sum = {1'b0, sc_r} + 33'(ENV_ONE / 2);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_N_W'({prod_r});
    div_req.divisor  = den_r;
    case (state_r)
      ST_Y2_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'({v2_r, FRAC_W'(0)});
        div_req.divisor  = DIV_D_W'(rin_r);
      end
      ST_Y1_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'({v1_r, FRAC_W'(0)});
        div_req.divisor  = DIV_D_W'(rin_r);
      end
      ST_DI_GO: begin
        div_req.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    last_nxt       = last_r;
    pos_nxt        = pos_r;
    rout_nxt       = rout_r;
    rin_nxt        = rin_r;
    prev_tick_nxt  = prev_tick_r;
    prev_val_nxt   = prev_val_r;
    x1_nxt         = x1_r;
    x2_nxt         = x2_r;
    v1_nxt         = v1_r;
    v2_nxt         = v2_r;
    pt0_nxt        = pt0_r;
    y1_nxt         = y1_r;
    y2_nxt         = y2_r;
    val_nxt        = val_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    den_nxt        = den_r;
    sc_nxt         = sc_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_WRITE) begin
            out_strobe_nxt = 1'b1;
            out_data_nxt   = '0;
          end else begin
            rd_idx_nxt  = '0;
            chk_vld_nxt = 1'b0;
            last_nxt    = AW'(n_eff - CW'(1));
            pos_nxt     = in_data.position;
            rout_nxt    = in_data.range_out;
            rin_nxt     = (range_in == '0) ? RIN_W'(1) : range_in;
            state_nxt   = ST_SCAN;
          end
        end
      end

      // Issue one read per cycle; check the entry read in the previous cycle
      ST_SCAN: begin
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = rd_idx_r;
        if (rd_idx_r != last_r) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (chk_vld_r) begin
          if ((pos_r <= ram_rdata.tick) || (chk_idx_r == last_r)) begin
            x2_nxt    = ram_rdata.tick;
            v2_nxt    = ram_rdata.value;
            pt0_nxt   = (chk_idx_r == '0);
            x1_nxt    = (chk_idx_r == '0) ? '0 : prev_tick_r;
            v1_nxt    = prev_val_r;
            state_nxt = ST_Y2_GO;
          end else begin
            prev_tick_nxt = ram_rdata.tick;
            prev_val_nxt  = ram_rdata.value;
          end
        end
      end

      ST_Y2_GO: begin
        state_nxt = ST_Y2_WAIT;
      end

      ST_Y2_WAIT: begin
        if (div_rsp.done) begin
          y2_nxt = div_rsp.quotient;
          if (pos_r >= x2_r) begin
            val_nxt   = div_rsp.quotient;
            state_nxt = ST_SCALE;
          end else if (!pt0_r) begin
            state_nxt = ST_Y1_GO;
          end else begin
            // Before the first point: start from value zero
            y1_nxt  = '0;
            val_nxt = '0;
            neg_nxt = 1'b0;
            state_nxt = interp ? ST_MUL : ST_SCALE;
          end
        end
      end

      ST_Y1_GO: begin
        state_nxt = ST_Y1_WAIT;
      end

      ST_Y1_WAIT: begin
        if (div_rsp.done) begin
          y1_nxt    = div_rsp.quotient;
          val_nxt   = div_rsp.quotient;
          neg_nxt   = y2_r < div_rsp.quotient;
          state_nxt = interp ? ST_MUL : ST_SCALE;
        end
      end

      ST_MUL: begin
        prod_nxt  = mul_w;
        den_nxt   = x2_r - x1_r;
        state_nxt = ST_DI_GO;
      end

      ST_DI_GO: begin
        state_nxt = ST_DI_WAIT;
      end

      // Truncate towards zero: apply the slope's sign to the magnitude quotient
      ST_DI_WAIT: begin
        if (div_rsp.done) begin
          val_nxt   = neg_r ? (y1_r - div_rsp.quotient) : (y1_r + div_rsp.quotient);
          state_nxt = ST_SCALE;
        end
      end

      ST_SCALE: begin
        sc_nxt    = clamp_v * rout_r;
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        out_strobe_nxt              = 1'b1;
        out_data_nxt.envelope_value = rnd_sum[FRAC_W +: ENV_W];
        out_data_nxt.was_query      = 1'b1;
        state_nxt                   = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      chk_vld_r    <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      chk_vld_r    <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    last_r      <= last_nxt;
    pos_r       <= pos_nxt;
    rout_r      <= rout_nxt;
    rin_r       <= rin_nxt;
    prev_tick_r <= prev_tick_nxt;
    prev_val_r  <= prev_val_nxt;
    x1_r        <= x1_nxt;
    x2_r        <= x2_nxt;
    v1_r        <= v1_nxt;
    v2_r        <= v2_nxt;
    pt0_r       <= pt0_nxt;
    y1_r        <= y1_nxt;
    y2_r        <= y2_nxt;
    val_r       <= val_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    den_r       <= den_nxt;
    sc_r        <= sc_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
`default_nettype wire

/* rtl/envelope_point_interpolation_core.sv */
// Top level: configuration registers, point table, shared divider and sequencer.
//
//   channel   direction  handshake              payload
//   in_       in         start / busy           in_data   (in_item_t)
//   out_      out        out_strobe, 1 cycle    out_data  (out_item_t)
//   cfg       in/out     psel/penable/pwrite    paddr, pwdata, prdata
//
// A write item is stored at acceptance; its result appears on the next cycle and
// busy stays low, so another item may follow straight away.
// A query holds busy while it scans the table with one table read per cycle, stopping at
// the first point at or beyond the position or at the last point in use, then makes one
// to three passes of the shared divider; the result shows as busy falls.
// Reset is synchronous and active low; the point table is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module envelope_point_interpolation_core
  import epi_pkg::*;
#(
  parameter int MAX_POINTS = EPI_MAX_POINTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_data,
  output logic             out_strobe,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_POINTS);

  logic [NCNT_W-1:0] node_count_r;
  logic [RIN_W-1:0]  range_in_r;
  logic              cfg_wr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  point_t            ram_wdata;
  logic [AW-1:0]     ram_raddr;
  point_t            ram_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCNT_W'(1);
      range_in_r   <= RIN_W'(64);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NODE_COUNT) begin
        node_count_r <= pwdata[NCNT_W-1:0];
      end else begin
        range_in_r <= pwdata[RIN_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_r) : 32'(range_in_r);

  epi_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  epi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  epi_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .node_count (node_count_r),
    .range_in   (range_in_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the envelope point interpolation core: directed plan, then random.
module tb;
  import epi_pkg::*;

  localparam int TABLE_DEPTH  = EPI_MAX_POINTS;
  localparam int ITEM_TARGET  = 750;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PLAN_LEN     = 24;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_NODES, ROW_RANGE} row_kind_t;

  // a/b/c: index/tick/value for writes, position/range_out for queries, c for registers
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [7:0]  c;
    logic        typed;
    logic [14:0] tv;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_strobe;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [TICK_W-1:0]      tick_tbl  [TABLE_DEPTH];
  logic [VAL_W-1:0]       level_tbl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written;
  logic [NCNT_W-1:0]      nodes_cfg;
  logic [RIN_W-1:0]       rin_cfg;
  out_item_t              envelope_q[$];
  plan_row_t              plan [PLAN_LEN];

  int errors = 0;
  int cycles = 0;
  int writes_seen = 0;
  int queries_seen = 0;
  int settings_seen = 0;
  int max_nodes = 0;
  int burst_left = 0;

  envelope_point_interpolation_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               envelope_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (envelope_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d was_query=%0d", $time,
                 out_data.envelope_value, out_data.was_query);
      end else begin
        want = envelope_q.pop_front();
        if (out_data.was_query !== want.was_query) begin
          errors++;
          $display("%0t: was_query expected %0d got %0d", $time, want.was_query,
                   out_data.was_query);
        end
        if (out_data.envelope_value !== want.envelope_value) begin
          errors++;
          $display("%0t: envelope_value expected %0d got %0d", $time, want.envelope_value,
                   out_data.envelope_value);
        end
      end
    end
  end

  function automatic int nodes_in_use();
    int n;
    n = nodes_cfg;
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic longint level_scaled(int idx, longint rin);
    longint v;
    v = level_tbl[idx];
    return (v * ENV_ONE) / rin;
  endfunction

  function automatic logic [ENV_W-1:0] envelope_at(logic [TICK_W-1:0] pos_in,
                                                   logic [ROUT_W-1:0] rout_in);
    int     n, pt, i;
    bit     found;
    longint rin, pos, rout, x1, x2, t, level, y2, scaled;
    n = nodes_in_use();
    rin = rin_cfg;
    if (rin == 0) rin = 1;
    pos = pos_in;
    rout = rout_in;
    pt = n - 1;
    found = 1'b0;
    // first point at or beyond the position, else the last one in use
    for (i = 0; i + 1 < n && !found; i++) begin
      t = tick_tbl[i];
      if (pos <= t) begin
        pt = i;
        found = 1'b1;
      end
    end
    x2 = tick_tbl[pt];
    x1 = 0;
    level = 0;
    if (pos >= x2) begin
      level = level_scaled(pt, rin);
    end else begin
      if (pt > 0) begin
        level = level_scaled(pt - 1, rin);
        x1 = tick_tbl[pt - 1];
      end
      if (x2 > x1 && pos > x1) begin
        y2 = level_scaled(pt, rin);
        level += ((pos - x1) * (y2 - level)) / (x2 - x1);
      end
    end
    if (level < 0) level = 0;
    if (level > ENV_ONE) level = ENV_ONE;
    scaled = (level * rout + ENV_ONE / 2) / ENV_ONE;
    return scaled[ENV_W-1:0];
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.action == ACT_WRITE) begin
      tick_tbl[it.point_index]  = it.point_tick;
      level_tbl[it.point_index] = it.point_value;
      written[it.point_index]   = 1'b1;
    end else begin
      r.envelope_value = envelope_at(it.position, it.range_out);
      r.was_query = 1'b1;
    end
    return r;
  endfunction

  function automatic in_item_t write_item(logic [IDX_W-1:0] idx, logic [TICK_W-1:0] tick,
                                          logic [VAL_W-1:0] lvl);
    in_item_t it;
    it.action      = ACT_WRITE;
    it.point_index = idx;
    it.point_tick  = tick;
    it.point_value = lvl;
    it.position    = TICK_W'($urandom_range(0, 65535));
    it.range_out   = ROUT_W'($urandom_range(0, 32767));
    return it;
  endfunction

  function automatic in_item_t query_item(logic [TICK_W-1:0] pos, logic [ROUT_W-1:0] rout);
    in_item_t it;
    it.action      = ACT_QUERY;
    it.point_index = IDX_W'($urandom_range(0, 31));
    it.point_tick  = TICK_W'($urandom_range(0, 65535));
    it.point_value = VAL_W'($urandom_range(0, 255));
    it.position    = pos;
    it.range_out   = rout;
    return it;
  endfunction

  task automatic drain_results();
    @(negedge clk) start <= 1'b0;
    while (envelope_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic issue(input in_item_t it, input bit typed, input logic [ENV_W-1:0] tv);
    out_item_t want;
    int        gap;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = apply_item(it);
    if (typed) want.envelope_value = tv;
    envelope_q.push_back(want);
    if (it.action == ACT_WRITE) writes_seen++;
    else queries_seen++;
    // bursts of back-to-back items, then a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic set_register(input logic reg_sel, input logic [7:0] val);
    logic [31:0] readback;
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {24'd0, val};
    @(negedge clk) penable <= 1'b1;
    // read it back straight after the write
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_NODE_COUNT) begin
      nodes_cfg = val[NCNT_W-1:0];
      readback = {26'd0, val[NCNT_W-1:0]};
    end else begin
      rin_cfg = val;
      readback = {24'd0, val};
    end
    if (prdata !== readback) begin
      errors++;
      $display("%0t: register %0d readback expected %0d got %0d", $time, reg_sel, readback,
               prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_seen++;
    if (nodes_in_use() > max_nodes) max_nodes = nodes_in_use();
  endtask

  initial begin
    int r, n, j, gap_idx, step, tk, pos, rout;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    written = '0;
    nodes_cfg = 6'd1;
    rin_cfg   = 8'd64;
    max_nodes = 1;

    plan[0]  = '{ROW_WRITE, 16'd0,     16'd100,   8'd64,  1'b1, 15'd0};
    plan[1]  = '{ROW_QUERY, 16'd0,     16'd32767, 8'd0,   1'b1, 15'd0};
    plan[2]  = '{ROW_QUERY, 16'd100,   16'd32767, 8'd0,   1'b1, 15'd32767};
    plan[3]  = '{ROW_QUERY, 16'd65535, 16'd32767, 8'd0,   1'b1, 15'd32767};
    plan[4]  = '{ROW_QUERY, 16'd50,    16'd32767, 8'd0,   1'b1, 15'd16384};
    plan[5]  = '{ROW_QUERY, 16'd50,    16'd0,     8'd0,   1'b1, 15'd0};
    plan[6]  = '{ROW_WRITE, 16'd0,     16'd0,     8'd255, 1'b1, 15'd0};
    plan[7]  = '{ROW_QUERY, 16'd0,     16'd32767, 8'd0,   1'b1, 15'd32767};
    plan[8]  = '{ROW_QUERY, 16'd65535, 16'd1,     8'd0,   1'b1, 15'd1};
    plan[9]  = '{ROW_WRITE, 16'd31,    16'd65535, 8'd0,   1'b1, 15'd0};
    plan[10] = '{ROW_WRITE, 16'd0,     16'd100,   8'd64,  1'b1, 15'd0};
    plan[11] = '{ROW_WRITE, 16'd1,     16'd200,   8'd0,   1'b1, 15'd0};
    plan[12] = '{ROW_NODES, 16'd0,     16'd0,     8'd2,   1'b0, 15'd0};
    plan[13] = '{ROW_QUERY, 16'd150,   16'd32767, 8'd0,   1'b0, 15'd0};
    plan[14] = '{ROW_QUERY, 16'd250,   16'd1000,  8'd0,   1'b1, 15'd0};
    // two points on the same tick
    plan[15] = '{ROW_WRITE, 16'd1,     16'd100,   8'd32,  1'b1, 15'd0};
    plan[16] = '{ROW_QUERY, 16'd100,   16'd32767, 8'd0,   1'b0, 15'd0};
    plan[17] = '{ROW_QUERY, 16'd101,   16'd32767, 8'd0,   1'b0, 15'd0};
    // a zero node count acts as one point
    plan[18] = '{ROW_NODES, 16'd0,     16'd0,     8'd0,   1'b0, 15'd0};
    plan[19] = '{ROW_QUERY, 16'd75,    16'd20000, 8'd0,   1'b0, 15'd0};
    // a zero input range acts as one, so the point value clamps to full scale
    plan[20] = '{ROW_RANGE, 16'd0,     16'd0,     8'd0,   1'b0, 15'd0};
    plan[21] = '{ROW_QUERY, 16'd100,   16'd12345, 8'd0,   1'b1, 15'd12345};
    plan[22] = '{ROW_RANGE, 16'd0,     16'd0,     8'd255, 1'b0, 15'd0};
    plan[23] = '{ROW_QUERY, 16'd60,    16'd32767, 8'd0,   1'b0, 15'd0};

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (r = 0; r < PLAN_LEN; r++) begin
      case (plan[r].kind)
        ROW_WRITE: issue(write_item(plan[r].a[IDX_W-1:0], plan[r].b, plan[r].c),
                         plan[r].typed, plan[r].tv);
        ROW_QUERY: issue(query_item(plan[r].a, plan[r].b[ROUT_W-1:0]),
                         plan[r].typed, plan[r].tv);
        ROW_NODES: set_register(REG_NODE_COUNT, plan[r].c);
        default:   set_register(REG_RANGE_IN, plan[r].c);
      endcase
    end

    while (writes_seen + queries_seen < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       set_register(REG_NODE_COUNT, 8'd0);
        1:       set_register(REG_NODE_COUNT, 8'd1);
        2:       set_register(REG_NODE_COUNT, 8'd32);
        3:       set_register(REG_NODE_COUNT, 8'd63);
        4:       set_register(REG_NODE_COUNT, 8'($urandom_range(33, 62)));
        5, 6:    set_register(REG_NODE_COUNT, 8'($urandom_range(1, 32)));
        default: set_register(REG_NODE_COUNT, 8'($urandom_range(2, 8)));
      endcase
      case ($urandom_range(0, 5))
        0:       set_register(REG_RANGE_IN, 8'd0);
        1:       set_register(REG_RANGE_IN, 8'd1);
        2:       set_register(REG_RANGE_IN, 8'd255);
        default: set_register(REG_RANGE_IN, 8'($urandom_range(1, 255)));
      endcase
      n = nodes_in_use();

      if ($urandom_range(0, 4) != 0) begin
        // ascending envelope with occasional flat steps
        tk = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3000);
        for (j = 0; j < n; j++) begin
          issue(write_item(IDX_W'(j), TICK_W'(tk), VAL_W'($urandom_range(0, 255))),
                1'b0, '0);
          step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 131070 / n);
          tk = (tk + step > 65535) ? 65535 : tk + step;
        end
      end else begin
        repeat ($urandom_range(1, n))
          issue(write_item(IDX_W'($urandom_range(0, 31)), TICK_W'($urandom_range(0, 65535)),
                           VAL_W'($urandom_range(0, 255))), 1'b0, '0);
      end

      repeat ($urandom_range(8, 40)) begin
        gap_idx = -1;
        for (j = n - 1; j >= 0; j--) if (!written[j]) gap_idx = j;
        if (gap_idx >= 0) begin
          // never query while a point in use is still unwritten
          issue(write_item(IDX_W'(gap_idx), TICK_W'($urandom_range(0, 65535)),
                           VAL_W'($urandom_range(0, 255))), 1'b0, '0);
        end else if ($urandom_range(0, 9) == 0) begin
          issue(write_item(IDX_W'($urandom_range(0, 31)), TICK_W'($urandom_range(0, 65535)),
                           VAL_W'($urandom_range(0, 255))), 1'b0, '0);
        end else begin
          tk = tick_tbl[$urandom_range(0, n - 1)];
          case ($urandom_range(0, 5))
            0:       pos = tk;
            1:       pos = (tk < 400) ? $urandom_range(0, tk) : tk - $urandom_range(0, 400);
            2:       pos = (tk > 65135) ? $urandom_range(tk, 65535) : tk + $urandom_range(0, 400);
            3:       pos = $urandom_range(0, 1) ? 65535 : 0;
            default: pos = $urandom_range(0, 65535);
          endcase
          case ($urandom_range(0, 7))
            0:       rout = 0;
            1:       rout = 32767;
            default: rout = $urandom_range(0, 32767);
          endcase
          issue(query_item(TICK_W'(pos), ROUT_W'(rout)), 1'b0, '0);
        end
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d point writes and %0d queries over %0d register writes.",
             writes_seen, queries_seen, settings_seen);
    $display("Up to %0d points in use; %0d mismatches found.", max_nodes, errors);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

/* envelope_point_interpolation_core.f */
rtl/epi_pkg.sv
rtl/epi_ram.sv
rtl/epi_div.sv
rtl/epi_ctrl.sv
rtl/envelope_point_interpolation_core.sv
dv/tb.sv
